>>> hw/rtl/ple_pkg.sv
// Package for the positional list engine: sizes, operation codes, the
// structs that pass between the sequencer and the step unit, value helpers.
// Used by every module of the block.
`timescale 1ns / 1ps

package ple_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;

    // fixed port field widths
    localparam int FUNC_W  = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 5;
    localparam int RCNT_W  = 5;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam int IN_TDATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_W + RCNT_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        OP_INSERT = 3'd0,
        OP_FIND   = 3'd1,
        OP_GET    = 3'd2,
        OP_FIRST  = 3'd3,
        OP_LAST   = 3'd4,
        OP_SIZE   = 3'd5
    } t_op;

    typedef struct packed {
        logic [IDX_W-1:0]       idx;
        logic [IDX_W-1:0]       stop;
        logic [VALUE_WIDTH-1:0] key;
        logic [VALUE_WIDTH-1:0] data;
    } t_step_in;

    typedef struct packed {
        logic                   match;
        logic [CNT_W-1:0]       idx_inc;
        logic [IDX_W-1:0]       idx_dec;
        logic                   at_stop;
        logic                   dec_at_stop;
    } t_step_out;

    // sign-extend the port value, keep the stored width
    function automatic logic [VALUE_WIDTH-1:0] to_store(input logic [DATA_W-1:0] v);
        logic signed [63:0] wide;
        wide = 64'(signed'(v));
        return wide[VALUE_WIDTH-1:0];
    endfunction

    // sign-extend a stored entry, keep the port width
    function automatic logic [DATA_W-1:0] to_port(input logic [VALUE_WIDTH-1:0] v);
        logic signed [63:0] wide;
        wide = 64'(signed'(v));
        return wide[DATA_W-1:0];
    endfunction

endpackage

>>> hw/rtl/ple_step.sv
// Shared step unit of the positional list engine: value compare, index
// increment and decrement, and end-of-walk detection.
// Depends on ple_pkg.
`timescale 1ns / 1ps

module ple_step
    import ple_pkg::*;
(
    input  t_step_in  i_step,
    output t_step_out o_step
);

    logic [IDX_W-1:0] dec;

    assign dec                 = i_step.idx - IDX_W'(1);
    assign o_step.match        = (i_step.key == i_step.data);
    assign o_step.idx_inc      = CNT_W'(i_step.idx) + CNT_W'(1);
    assign o_step.idx_dec      = dec;
    assign o_step.at_stop      = (i_step.idx == i_step.stop);
    assign o_step.dec_at_stop  = (dec == i_step.stop);

endmodule

>>> hw/rtl/positional_list_engine.sv
// Top level of the positional list engine: command sequencer, entry memory
// and result register. Depends on ple_pkg and ple_step.
`timescale 1ns / 1ps

// Usage
//   Commands arrive on the s_axis channel, one word per command: func in
//   tuser, value and position in tdata. Each command yields exactly one
//   result word on m_axis: result_value and result_count in tdata, the
//   error flag in tuser.
//   One command is worked at a time; s_axis_tready is high only while the
//   sequencer is idle and out of reset. All entry traffic goes through one
//   single-port-read memory and one shared step unit. An insert moves each
//   entry from the position upward back one place, then writes the value;
//   find compares entries from the head until a match or the last entry;
//   get/first/last read one entry; size and a failed check read none.
//   Each moved or compared entry takes a memory read followed by a write
//   or a compare.
//   The result sits in an output register; the next command is accepted
//   while it waits. If the receiver stalls, a finished result holds in the
//   sequencer until the output register frees.
//   Reset empties the list (count to zero) and drops any pending result.
//   Entry contents are not cleared; no entry is read before it is written.

module positional_list_engine
    import ple_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] value, [36:32] position, [39:37] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [2:0] func
    input  logic [FUNC_W-1:0]      s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [31:0] result_value, [36:32] result_count, [39:37] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // [0] error
    output logic [0:0]             m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_GET_RD,
        S_GET_DATA,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [IDX_W-1:0]       r_pos, n_pos;
    logic [VALUE_WIDTH-1:0] r_value, n_value;
    logic [DATA_W-1:0]      r_res_value, n_res_value;
    logic [RCNT_W-1:0]      r_res_count, n_res_count;
    logic                   r_res_err, n_res_err;
    logic                   r_out_valid, n_out_valid;
    logic [DATA_W-1:0]      r_out_value, n_out_value;
    logic [RCNT_W-1:0]      r_out_count, n_out_count;
    logic                   r_out_err, n_out_err;

    logic [VALUE_WIDTH-1:0] r_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] r_rd_data;
    logic                   mem_we;
    logic [IDX_W-1:0]       mem_wa;
    logic [VALUE_WIDTH-1:0] mem_wd;
    logic [IDX_W-1:0]       mem_ra;

    t_step_in               step_in;
    t_step_out              step_out;

    logic [DATA_W-1:0]      in_value;
    logic [POS_W-1:0]       in_pos;
    logic [CMP_W-1:0]       pos_ext;
    logic [CMP_W-1:0]       cnt_ext;
    logic [IDX_W-1:0]       last_idx;
    logic                   out_free;

    assign in_value = s_axis_tdata[DATA_W-1:0];
    assign in_pos   = s_axis_tdata[DATA_W+POS_W-1:DATA_W];
    assign pos_ext  = CMP_W'(in_pos);
    assign cnt_ext  = CMP_W'(r_count);
    assign last_idx = IDX_W'(r_count - CNT_W'(1));
    assign out_free = !r_out_valid || m_axis_tready;

    assign step_in.idx  = r_idx;
    assign step_in.stop = (r_state == S_SCAN_CMP) ? last_idx : r_pos;
    assign step_in.key  = r_value;
    assign step_in.data = r_rd_data;

    ple_step u_step (
        .i_step (step_in),
        .o_step (step_out)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_value     = r_value;
        n_res_value = r_res_value;
        n_res_count = r_res_count;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid;
        n_out_value = r_out_value;
        n_out_count = r_out_count;
        n_out_err   = r_out_err;
        mem_we      = 1'b0;
        mem_wa      = r_idx;
        mem_wd      = r_rd_data;
        mem_ra      = r_idx;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_value     = to_store(in_value);
                    n_pos       = IDX_W'(in_pos);
                    n_res_value = '0;
                    n_res_count = '0;
                    n_res_err   = 1'b0;
                    n_state     = S_DONE;
                    unique case (s_axis_tuser)
                        OP_INSERT: begin
                            if (r_count >= CNT_W'(CAPACITY) || pos_ext > cnt_ext) begin
                                n_res_err = 1'b1;
                            end else if (pos_ext == cnt_ext) begin
                                n_idx   = IDX_W'(in_pos);
                                n_state = S_INS_WR;
                            end else begin
                                n_idx   = IDX_W'(r_count);
                                n_state = S_SHIFT_RD;
                            end
                        end
                        OP_FIND: begin
                            if (r_count == '0) begin
                                n_res_err = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_SCAN_RD;
                            end
                        end
                        OP_GET: begin
                            if (pos_ext < cnt_ext) begin
                                n_idx   = IDX_W'(in_pos);
                                n_state = S_GET_RD;
                            end else begin
                                n_res_err = 1'b1;
                            end
                        end
                        OP_FIRST: begin
                            if (r_count == '0) begin
                                n_res_err = 1'b1;
                            end else begin
                                n_idx   = '0;
                                n_state = S_GET_RD;
                            end
                        end
                        OP_LAST: begin
                            if (r_count == '0) begin
                                n_res_err = 1'b1;
                            end else begin
                                n_idx   = last_idx;
                                n_state = S_GET_RD;
                            end
                        end
                        OP_SIZE: begin
                            n_res_count = RCNT_W'(r_count);
                        end
                        default: begin
                            n_res_err = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT_RD: begin
                mem_ra  = step_out.idx_dec;
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // move the entry below back one place
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = r_rd_data;
                n_idx  = step_out.idx_dec;
                n_state = step_out.dec_at_stop ? S_INS_WR : S_SHIFT_RD;
            end
            S_INS_WR: begin
                mem_we  = 1'b1;
                mem_wa  = r_idx;
                mem_wd  = r_value;
                n_count = r_count + CNT_W'(1);
                n_state = S_DONE;
            end
            S_SCAN_RD: begin
                mem_ra  = r_idx;
                n_state = S_SCAN_CMP;
            end
            S_SCAN_CMP: begin
                priority if (step_out.match) begin
                    n_res_count = RCNT_W'(step_out.idx_inc);
                    n_state     = S_DONE;
                end else if (step_out.at_stop) begin
                    n_res_err = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_idx   = step_out.idx_inc[IDX_W-1:0];
                    n_state = S_SCAN_RD;
                end
            end
            S_GET_RD: begin
                mem_ra  = r_idx;
                n_state = S_GET_DATA;
            end
            S_GET_DATA: begin
                n_res_value = to_port(r_rd_data);
                n_state     = S_DONE;
            end
            S_DONE: begin
                // hold the result until the output register frees
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_res_value;
                    n_out_count = r_res_count;
                    n_out_err   = r_res_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_value     <= n_value;
        r_res_value <= n_res_value;
        r_res_count <= n_res_count;
        r_res_err   <= n_res_err;
        r_out_value <= n_out_value;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[mem_ra];
    end

    assign s_axis_tready   = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = OUT_TDATA_W'({r_out_count, r_out_value});
    assign m_axis_tuser[0] = r_out_err;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            ($past(r_state) == S_INS_WR && r_count == $past(r_count) + CNT_W'(1)))
        else $error("entry count changed outside an insert write");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("failed command carries nonzero result fields");

endmodule

>>> sim/positional_list_engine_test.sv
// Self-checking bench for positional_list_engine: a queue-fed command driver, a result monitor
// and a behavioral list model that predicts every result word. Depends on ple_pkg.
`timescale 1ns / 1ps

module positional_list_engine_test;
    import ple_pkg::*;

    localparam int RANDOM_ITEMS = 1080;
    localparam int TAIL_ITEMS   = 120;
    localparam int DRAIN_CYCLES = 80;
    localparam int PRINT_CAP    = 100;

    // function codes the block does not implement
    localparam logic [FUNC_W-1:0] OP_RSVD_A = 3'd6;
    localparam logic [FUNC_W-1:0] OP_RSVD_B = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] value;
        logic [POS_W-1:0]  pos;
    } t_list_cmd;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [RCNT_W-1:0] count;
        logic              err;
    } t_list_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [31:0] value, [36:32] position, [39:37] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // [2:0] func
    logic [FUNC_W-1:0]      s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [31:0] result_value, [36:32] result_count, [39:37] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // [0] error
    logic [0:0]             m_axis_tuser;

    positional_list_engine uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_list_cmd    pending_q[$];
    t_list_answer expected_q[$];
    int           fail_count = 0;

    // model of the list contents
    logic [VALUE_WIDTH-1:0] list_mem [CAPACITY];
    int unsigned            list_len = 0;

    function automatic t_list_answer apply_list_op(input logic [FUNC_W-1:0] func,
                                                   input logic [DATA_W-1:0] value,
                                                   input logic [POS_W-1:0]  pos);
        t_list_answer ans;
        logic [VALUE_WIDTH-1:0] key;
        key = VALUE_WIDTH'(value);
        ans.value = '0;
        ans.count = '0;
        ans.err   = 1'b0;
        case (func)
            OP_INSERT: begin
                if (list_len >= CAPACITY || pos > list_len) begin
                    ans.err = 1'b1;
                end else begin
                    for (int i = list_len; i > pos; i--)
                        list_mem[IDX_W'(i)] = list_mem[IDX_W'(i-1)];
                    list_mem[IDX_W'(pos)] = key;
                    list_len++;
                end
            end
            OP_FIND: begin
                ans.err = 1'b1;
                for (int i = 0; i < list_len; i++) begin
                    if (ans.err && list_mem[IDX_W'(i)] == key) begin
                        ans.count = RCNT_W'(i + 1);
                        ans.err   = 1'b0;
                    end
                end
            end
            OP_GET: begin
                if (pos < list_len)
                    ans.value = DATA_W'(signed'(list_mem[IDX_W'(pos)]));
                else
                    ans.err = 1'b1;
            end
            OP_FIRST: begin
                if (list_len > 0)
                    ans.value = DATA_W'(signed'(list_mem[0]));
                else
                    ans.err = 1'b1;
            end
            OP_LAST: begin
                if (list_len > 0)
                    ans.value = DATA_W'(signed'(list_mem[IDX_W'(list_len-1)]));
                else
                    ans.err = 1'b1;
            end
            OP_SIZE: begin
                ans.count = RCNT_W'(list_len);
            end
            default: begin
                ans.err = 1'b1;
            end
        endcase
        if (ans.err) begin
            ans.value = '0;
            ans.count = '0;
        end
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        if (fail_count < PRINT_CAP)
            $display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // command driver
    t_list_cmd drv_cmd;
    int        drv_gap = 0;
    logic      drv_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            drv_gap       <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(apply_list_op(s_axis_tuser, s_axis_tdata[DATA_W-1:0],
                                                   s_axis_tdata[DATA_W +: POS_W]));
                if ($urandom_range(0, 63) == 0)
                    drv_calm <= !drv_calm;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (drv_gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    drv_gap       <= drv_gap - 1;
                end else if (pending_q.size() >= TAIL_ITEMS && !drv_calm &&
                             $urandom_range(0, 4) == 0) begin
                    s_axis_tvalid <= 1'b0;
                    drv_gap       <= $urandom_range(0, 8);
                end else if (pending_q.size() != 0) begin
                    drv_cmd        = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_TDATA_W'({drv_cmd.pos, drv_cmd.value});
                    s_axis_tuser  <= drv_cmd.func;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    t_list_answer mon_want;
    int           mon_stall = 0;
    logic         mon_calm = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            mon_stall     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata[DATA_W-1:0], '0);
                end else begin
                    mon_want = expected_q.pop_front();
                    if (m_axis_tdata[DATA_W-1:0] !== mon_want.value)
                        report_mismatch("result_value", m_axis_tdata[DATA_W-1:0],
                                        mon_want.value);
                    if (m_axis_tdata[DATA_W +: RCNT_W] !== mon_want.count)
                        report_mismatch("result_count", DATA_W'(m_axis_tdata[DATA_W +: RCNT_W]),
                                        DATA_W'(mon_want.count));
                    if (m_axis_tuser[0] !== mon_want.err)
                        report_mismatch("error", DATA_W'(m_axis_tuser[0]),
                                        DATA_W'(mon_want.err));
                end
                if ($urandom_range(0, 63) == 0)
                    mon_calm <= !mon_calm;
            end
            if (mon_stall != 0) begin
                m_axis_tready <= 1'b0;
                mon_stall     <= mon_stall - 1;
            end else if (pending_q.size() >= TAIL_ITEMS && !mon_calm &&
                         $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                mon_stall     <= $urandom_range(0, 8);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // stimulus
    int unsigned       plan_len = 0;
    logic [DATA_W-1:0] value_pool[$];

    task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value,
                             input logic [POS_W-1:0] pos);
        t_list_cmd c;
        c.func  = func;
        c.value = value;
        c.pos   = pos;
        pending_q.push_back(c);
        if (func == OP_INSERT) begin
            value_pool.push_back(value);
            if (plan_len < CAPACITY && pos <= plan_len)
                plan_len++;
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            4, 5:    return (value_pool.size() != 0) ?
                            value_pool[$urandom_range(0, value_pool.size() - 1)] : $urandom;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int r;
        logic [POS_W-1:0] p;

        // empty list: every read fails, size answers zero
        queue_cmd(OP_SIZE,  $urandom, POS_W'($urandom));
        queue_cmd(OP_FIRST, $urandom, POS_W'($urandom));
        queue_cmd(OP_LAST,  $urandom, POS_W'($urandom));
        queue_cmd(OP_GET,   $urandom, 5'd0);
        queue_cmd(OP_FIND,  32'h0000_0000, POS_W'($urandom));
        queue_cmd(OP_RSVD_A, $urandom, 5'd0);
        queue_cmd(OP_RSVD_B, '1, '1);
        queue_cmd(OP_INSERT, 32'h1234_5678, 5'd1);
        queue_cmd(OP_INSERT, 32'h1234_5678, 5'd31);
        // build 0x80000000, 0, 0x7fffffff, -1
        queue_cmd(OP_INSERT, 32'h7fff_ffff, 5'd0);
        queue_cmd(OP_INSERT, 32'h8000_0000, 5'd0);
        queue_cmd(OP_INSERT, 32'hffff_ffff, 5'd2);
        queue_cmd(OP_INSERT, 32'h0000_0000, 5'd1);
        queue_cmd(OP_INSERT, 32'h5555_5555, 5'd5);
        queue_cmd(OP_GET,   $urandom, 5'd3);
        queue_cmd(OP_GET,   $urandom, 5'd4);
        queue_cmd(OP_GET,   $urandom, 5'd31);
        queue_cmd(OP_FIRST, $urandom, POS_W'($urandom));
        queue_cmd(OP_LAST,  $urandom, POS_W'($urandom));
        queue_cmd(OP_FIND,  32'hffff_ffff, POS_W'($urandom));
        queue_cmd(OP_FIND,  32'h8000_0000, POS_W'($urandom));
        queue_cmd(OP_FIND,  32'h0012_3456, POS_W'($urandom));
        queue_cmd(OP_SIZE,  $urandom, POS_W'($urandom));
        queue_cmd(OP_INSERT, 32'h0000_0000, 5'd4);
        queue_cmd(OP_FIND,  32'h0000_0000, POS_W'($urandom));

        repeat (RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 4) == 0)
                p = POS_W'($urandom);
            else
                p = POS_W'($urandom_range(0, plan_len));
            if (r < 30)
                queue_cmd(OP_INSERT, pick_value(), p);
            else if (r < 55)
                queue_cmd(OP_FIND, pick_value(), POS_W'($urandom));
            else if (r < 72)
                queue_cmd(OP_GET, $urandom, p);
            else if (r < 80)
                queue_cmd(OP_FIRST, $urandom, POS_W'($urandom));
            else if (r < 88)
                queue_cmd(OP_LAST, $urandom, POS_W'($urandom));
            else if (r < 94)
                queue_cmd(OP_SIZE, $urandom, POS_W'($urandom));
            else
                queue_cmd($urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B, $urandom,
                          POS_W'($urandom));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !s_axis_tvalid);
        wait (expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
